[design/assert_macros.svh]
// Assertion macros used by the tracker controller.
// Depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/tcvt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the tag velocity tracker.
// Depends on nothing.
package tcvt_pkg;
    localparam int POS_W = 32;
    localparam int DP_W  = 33;
    localparam int NUM_W = 49;   // dp * 2^16
    localparam int SUM_W = 34;
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_SAMPLE, ST_RD_OLD, ST_RD_NEW,
        ST_DIV_START, ST_DIV_RUN, ST_DIV_NEXT, ST_OUT
    } state_t;

    typedef struct packed {
        logic clear_meta;   // zero one per-tag counter entry
        logic load_in;      // capture input word
        logic sample_wr;    // update sums, commit on corner 3
        logic rd_old;       // read oldest slot
        logic rd_new;       // read newest slot
        logic latch_old;    // capture oldest read data
        logic latch_new;    // form dx, dy, dz and dt from newest read data
        logic div_start;    // start division on current axis
        logic div_step;     // one quotient bit
        logic div_store;    // store quotient, advance axis
        logic clear_res;    // zero velocity fields
    } cmd_t;

    typedef struct packed {
        logic        clear_done;  // last counter entry being cleared
        logic        is_query;
        logic        tag_ok;
        logic        enough;      // at least two samples
        logic        dt_zero;
        logic        div_done;
        logic        last_axis;
    } sts_t;
endpackage

[design/tcvt_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
// Depends on nothing.
module tcvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 640
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[design/tcvt_ctrl.sv]
`timescale 1ns / 1ps
// Controller state machine of the tag velocity tracker.
// Depends on tcvt_pkg and assert_macros.svh.
`include "assert_macros.svh"
module tcvt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic            out_fire,
    input  tcvt_pkg::sts_t  sts,
    output tcvt_pkg::cmd_t  cmd,
    output logic            in_ready,
    output logic            out_valid
);
    import tcvt_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SAMPLE;
                end
            end
            ST_SAMPLE:
            begin
                if (!sts.is_query)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.tag_ok)
                begin
                    state_next = ST_IDLE;
                end
                else if (!sts.enough)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RD_OLD;
                end
            end
            ST_RD_OLD:    state_next = ST_RD_NEW;
            ST_RD_NEW:    state_next = ST_DIV_START;
            ST_DIV_START:
            begin
                state_next = sts.dt_zero ? ST_OUT : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_DIV_NEXT;
                end
            end
            ST_DIV_NEXT:
            begin
                state_next = sts.last_axis ? ST_OUT : ST_DIV_START;
            end
            ST_OUT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_CLEAR:     cmd.clear_meta = 1'b1;
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = 1'b1;
            end
            ST_SAMPLE:
            begin
                cmd.sample_wr = !sts.is_query;
                cmd.rd_old    = sts.is_query;
                cmd.clear_res = 1'b1;
            end
            ST_RD_OLD:
            begin
                cmd.rd_new    = 1'b1;
                cmd.latch_old = 1'b1;
            end
            ST_RD_NEW:    cmd.latch_new  = 1'b1;
            ST_DIV_START: cmd.div_start  = !sts.dt_zero;
            ST_DIV_RUN:   cmd.div_step   = 1'b1;
            ST_DIV_NEXT:  cmd.div_store  = 1'b1;
            ST_OUT:       out_valid      = 1'b1;
            default:      cmd            = '0;
        endcase
    end

    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ready, !out_valid)
    `ASSERT_NEXT(a_out_held, clk, rst_n, out_valid && !out_fire, out_valid)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, out_fire, in_ready)
endmodule

[design/tcvt_dp.sv]
`timescale 1ns / 1ps
// Datapath: corner sums, per-tag history, differences and restoring divider.
// Depends on tcvt_pkg and tcvt_ram.
module tcvt_dp #(
    parameter int HISTORY_DEPTH = 10,
    parameter int NUM_TAGS      = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcvt_pkg::cmd_t      cmd,
    output tcvt_pkg::sts_t      sts,
    input  logic                req_type,
    input  logic [5:0]          tag_id,
    input  logic [1:0]          corner_index,
    input  logic [31:0]         corner_x,
    input  logic [31:0]         corner_y,
    input  logic [31:0]         corner_z,
    input  logic [31:0]         sample_time,
    output logic [5:0]          result_tag,
    output logic [31:0]         vel_x,
    output logic [31:0]         vel_y,
    output logic [31:0]         vel_z,
    output logic                vel_valid,
    output logic                vel_saturated
);
    import tcvt_pkg::*;

    localparam int SLOTS = NUM_TAGS * HISTORY_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int TW    = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int HW    = $clog2(HISTORY_DEPTH + 1);
    localparam int DW    = $clog2(HISTORY_DEPTH);
    localparam int MW    = HW + DW;
    localparam int CW    = $clog2(NUM_W + 1);

    // input capture
    logic        req_reg;
    logic [5:0]  tag_reg;
    logic [1:0]  corner_reg;
    logic [31:0] cx_reg, cy_reg, cz_reg, time_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= req_type;
            tag_reg    <= tag_id;
            corner_reg <= corner_index;
            cx_reg     <= corner_x;
            cy_reg     <= corner_y;
            cz_reg     <= corner_z;
            time_reg   <= sample_time;
        end
    end

    logic tag_ok;
    assign tag_ok = {26'd0, tag_reg} < 32'(NUM_TAGS);
    logic [TW-1:0] tidx;
    assign tidx = TW'(tag_reg);

    // corner sums
    logic [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic [SUM_W-1:0] sx_next, sy_next, sz_next;
    logic             load0;
    assign load0   = (corner_reg == 2'd0);
    assign sx_next = (load0 ? '0 : sx_reg) + SUM_W'($signed(cx_reg));
    assign sy_next = (load0 ? '0 : sy_reg) + SUM_W'($signed(cy_reg));
    assign sz_next = (load0 ? '0 : sz_reg) + SUM_W'($signed(cz_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
        end
        else if (cmd.sample_wr)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            sz_reg <= sz_next;
        end
    end

    // per-tag count and oldest slot, one RAM entry per tag
    logic [TW-1:0] clr_reg;
    logic          meta_we;
    logic [TW-1:0] meta_addr;
    logic [MW-1:0] meta_wdata, meta_rd;
    logic [HW-1:0] cnt;
    logic [DW-1:0] old;
    assign cnt = meta_rd[HW-1:0];
    assign old = meta_rd[MW-1:HW];

    logic commit;
    assign commit = cmd.sample_wr && (corner_reg == 2'd3) && tag_ok;
    logic full;
    assign full = (cnt == HW'(HISTORY_DEPTH));

    function automatic logic [DW-1:0] wrap(input logic [HW:0] v);
        logic [HW:0] r;
        r = (v >= (HW+1)'(HISTORY_DEPTH)) ? v - (HW+1)'(HISTORY_DEPTH) : v;
        return DW'(r);
    endfunction

    logic [DW-1:0] wslot, oslot, nslot;
    assign wslot = full ? old : wrap((HW+1)'(old) + (HW+1)'(cnt));
    assign oslot = old;
    assign nslot = wrap((HW+1)'(old) + (HW+1)'(cnt) - 1'b1);

    logic [HW-1:0] cnt_next;
    logic [DW-1:0] old_next;
    assign cnt_next   = full ? cnt : cnt + 1'b1;
    assign old_next   = full ? wrap((HW+1)'(old) + 1'b1) : old;
    assign meta_we    = cmd.clear_meta || commit;
    assign meta_wdata = cmd.clear_meta ? '0 : {old_next, cnt_next};

    always_comb
    begin
        meta_addr = tidx;
        if (cmd.clear_meta)
        begin
            meta_addr = clr_reg;
        end
        else if (cmd.load_in)
        begin
            meta_addr = TW'(tag_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_meta)
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    tcvt_ram #(.WIDTH(MW), .DEPTH(1 << TW)) u_meta (.clk(clk), .we(meta_we),
        .addr(meta_addr), .wdata(meta_wdata), .rdata(meta_rd));

    // history memories
    logic [AW-1:0] base, addr;
    assign base = AW'(tidx * HISTORY_DEPTH);
    always_comb
    begin
        addr = base + AW'(wslot);
        if (cmd.rd_old)
        begin
            addr = base + AW'(oslot);
        end
        else if (cmd.rd_new)
        begin
            addr = base + AW'(nslot);
        end
    end

    logic [31:0] rx, ry, rz, rt;
    tcvt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hx (.clk(clk), .we(commit), .addr(addr),
        .wdata(sx_next[33:2]), .rdata(rx));
    tcvt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hy (.clk(clk), .we(commit), .addr(addr),
        .wdata(sy_next[33:2]), .rdata(ry));
    tcvt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_hz (.clk(clk), .we(commit), .addr(addr),
        .wdata(sz_next[33:2]), .rdata(rz));
    tcvt_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_ht (.clk(clk), .we(commit), .addr(addr),
        .wdata(time_reg), .rdata(rt));

    // differences
    logic [31:0] ox_reg, oy_reg, oz_reg, ot_reg;
    logic signed [DP_W-1:0] dx_reg, dy_reg, dz_reg, dt_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.latch_old)
        begin
            ox_reg <= rx;
            oy_reg <= ry;
            oz_reg <= rz;
            ot_reg <= rt;
        end
        if (cmd.latch_new)
        begin
            dx_reg <= DP_W'($signed(rx)) - DP_W'($signed(ox_reg));
            dy_reg <= DP_W'($signed(ry)) - DP_W'($signed(oy_reg));
            dz_reg <= DP_W'($signed(rz)) - DP_W'($signed(oz_reg));
            dt_reg <= $signed({1'b0, rt}) - $signed({1'b0, ot_reg});
        end
    end

    // restoring divider on magnitudes, one bit a cycle
    logic [1:0]        axis_reg;
    logic [NUM_W-1:0]  quo_reg, rem_reg;
    logic [31:0]       dv_reg;
    logic [CW-1:0]     bit_reg;
    logic              neg_reg;
    logic signed [DP_W-1:0] dsel;
    always_comb
    begin
        case (axis_reg)
            2'd0:    dsel = dx_reg;
            2'd1:    dsel = dy_reg;
            default: dsel = dz_reg;
        endcase
    end

    logic [DP_W-1:0] dmag, tmag;
    assign dmag = dsel[DP_W-1] ? DP_W'(-dsel) : dsel;
    assign tmag = dt_reg[DP_W-1] ? DP_W'(-dt_reg) : dt_reg;

    logic [NUM_W:0] trial;
    assign trial = {rem_reg, quo_reg[NUM_W-1]} - (NUM_W+1)'(dv_reg);

    // signed result and saturation
    logic [NUM_W:0]  sq;
    logic            ovf;
    logic [31:0]     qsat;
    assign sq   = neg_reg ? (NUM_W+1)'(-{1'b0, quo_reg}) : {1'b0, quo_reg};
    assign ovf  = neg_reg ? (quo_reg > NUM_W'(33'h80000000))
                          : (quo_reg > NUM_W'(32'h7FFFFFFF));
    assign qsat = ovf ? (neg_reg ? 32'h80000000 : 32'h7FFFFFFF) : sq[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg <= '0;
            bit_reg  <= '0;
        end
        else if (cmd.clear_res)
        begin
            axis_reg <= '0;
            bit_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            bit_reg <= CW'(NUM_W);
        end
        else if (cmd.div_step && bit_reg != '0)
        begin
            bit_reg <= bit_reg - 1'b1;
        end
        else if (cmd.div_store)
        begin
            axis_reg <= axis_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg <= {dmag, 16'd0};
            rem_reg <= '0;
            dv_reg  <= tmag[31:0];
            neg_reg <= dsel[DP_W-1] ^ dt_reg[DP_W-1];
        end
        else if (cmd.div_step && bit_reg != '0)
        begin
            if (!trial[NUM_W])
            begin
                rem_reg <= trial[NUM_W-1:0];
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[NUM_W-2:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_valid     <= 1'b0;
            vel_saturated <= 1'b0;
        end
        else if (cmd.clear_res)
        begin
            vel_valid     <= 1'b0;
            vel_saturated <= 1'b0;
        end
        else if (cmd.div_store)
        begin
            vel_valid     <= 1'b1;
            vel_saturated <= vel_saturated | ovf;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_res)
        begin
            result_tag <= tag_reg;
            vel_x      <= '0;
            vel_y      <= '0;
            vel_z      <= '0;
        end
        else if (cmd.div_store)
        begin
            case (axis_reg)
                2'd0:    vel_x <= qsat;
                2'd1:    vel_y <= qsat;
                default: vel_z <= qsat;
            endcase
        end
    end

    assign sts.clear_done = (clr_reg == '1);
    assign sts.is_query   = (req_reg == REQ_QUERY);
    assign sts.tag_ok     = tag_ok;
    assign sts.enough     = (cnt >= HW'(2));
    assign sts.dt_zero    = (dt_reg == '0);
    assign sts.div_done   = (bit_reg == CW'(1));
    assign sts.last_axis  = (axis_reg == 2'd2);
endmodule

[design/tag_centroid_velocity_tracker.sv]
`timescale 1ns / 1ps
// Top level of the tag velocity tracker: stream ports, controller, datapath.
// Depends on tcvt_pkg, tcvt_ctrl, tcvt_dp.
//
// One word at a time. After reset s_axis_tready stays low while all 2**ceil(log2(NUM_TAGS))
// per-tag counter entries (64 by default) are cleared. A sample word updates the corner
// sums and returns to idle. A query goes through a lookup state and two history reads,
// then per axis a start state, 49 restoring divider steps and a store state, then presents
// the result and returns to idle. A query with fewer than two samples presents an invalid
// result without reading the history, and one with a zero time span skips the division.
// The result stays on m_axis until taken.
module tag_centroid_velocity_tracker #(
    parameter int HISTORY_DEPTH = 10,
    parameter int NUM_TAGS      = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: tag_id[5:0], corner_index[7:6], corner_x[39:8], corner_y[71:40],
    // corner_z[103:72], sample_time[135:104]
    input  logic [135:0] s_axis_tdata,
    // tuser: req_type
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: result_tag[5:0], vel_x[37:6], vel_y[69:38], vel_z[101:70],
    // vel_valid[102], vel_saturated[103]
    output logic [103:0] m_axis_tdata
);
    import tcvt_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic in_fire, out_fire;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    tcvt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_fire(out_fire),
        .sts(sts), .cmd(cmd), .in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
    );

    tcvt_dp #(.HISTORY_DEPTH(HISTORY_DEPTH), .NUM_TAGS(NUM_TAGS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .req_type(s_axis_tuser),
        .tag_id(s_axis_tdata[5:0]),
        .corner_index(s_axis_tdata[7:6]),
        .corner_x(s_axis_tdata[39:8]),
        .corner_y(s_axis_tdata[71:40]),
        .corner_z(s_axis_tdata[103:72]),
        .sample_time(s_axis_tdata[135:104]),
        .result_tag(m_axis_tdata[5:0]),
        .vel_x(m_axis_tdata[37:6]),
        .vel_y(m_axis_tdata[69:38]),
        .vel_z(m_axis_tdata[101:70]),
        .vel_valid(m_axis_tdata[102]),
        .vel_saturated(m_axis_tdata[103])
    );
endmodule
